// ===== hw/rtl/base62_codec_macros.svh =====
// ----------------------------------------------------------------------------
// base62 codec assertion macros
// shared property wrappers, clocked on clk_i and disabled in reset
// ----------------------------------------------------------------------------
`ifndef BASE62_CODEC_MACROS_SVH
`define BASE62_CODEC_MACROS_SVH

// plain property that must hold at every edge
`define B62C_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define B62C_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hw/rtl/b62c_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b62c_pkg
// shared types, codes and character mapping of the base62 codec
// ----------------------------------------------------------------------------
package b62c_pkg;

  localparam int unsigned VALUE_W    = 8;
  localparam int unsigned LEN_W      = 6;
  localparam int unsigned ERR_W      = 2;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_CHAR     = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LENGTH = 8'd1;

  localparam logic [LEN_W-1:0] OUT_LEN_RESET = 6'd22;

  // ascii bounds of the alphabet
  localparam logic [VALUE_W-1:0] CH_0  = 8'h30;
  localparam logic [VALUE_W-1:0] CH_9  = 8'h39;
  localparam logic [VALUE_W-1:0] CH_LA = 8'h61;
  localparam logic [VALUE_W-1:0] CH_LZ = 8'h7a;
  localparam logic [VALUE_W-1:0] CH_UA = 8'h41;
  localparam logic [VALUE_W-1:0] CH_UZ = 8'h5a;

  typedef struct packed {
    logic               ok;
    logic [VALUE_W-1:0] digit;
  } digit_t;

  typedef struct packed {
    logic               en;
    logic [VALUE_W-1:0] data;
  } ld_wr_t;

  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value;
  } rem_t;

  typedef struct packed {
    logic             start;
    logic             err;
    logic             dir;
    logic [ERR_W-1:0] code;
    logic [LEN_W-1:0] len;
  } emit_cmd_t;

  function automatic digit_t char_to_digit(input logic [VALUE_W-1:0] c);
    digit_t d;
    d.ok    = 1'b1;
    d.digit = c;
    if (c >= CH_0 && c <= CH_9) begin
      d.digit = c - CH_0;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d.digit = c - CH_LA + 8'd10;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d.digit = c - CH_UA + 8'd36;
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

  function automatic logic [VALUE_W-1:0] digit_to_char(input logic [5:0] d);
    logic [VALUE_W-1:0] dx;
    dx = {2'b00, d};
    if (d < 6'd10) begin
      return CH_0 + dx;
    end else if (d < 6'd36) begin
      return CH_LA + dx - 8'd10;
    end else begin
      return CH_UA + dx - 8'd36;
    end
  endfunction

endpackage

// ===== hw/rtl/b62c_div.sv =====
`timescale 1ns / 1ps
`include "base62_codec_macros.svh"
// ----------------------------------------------------------------------------
// b62c_div
// digit store and long division sequencer, one stored digit per cycle within a pass
// ----------------------------------------------------------------------------
module b62c_div
  import b62c_pkg::*;
#(
  parameter int unsigned  MAX_DIGITS = 48,
  localparam int unsigned IDX_W      = $clog2(MAX_DIGITS),
  localparam int unsigned CNT_W      = $clog2(MAX_DIGITS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ld_wr_t           ld_i,
  input  logic [IDX_W-1:0] ld_addr_i,
  input  logic             start_i,
  input  logic             dir_i,
  input  logic [CNT_W-1:0] count_i,
  input  logic [LEN_W-1:0] passes_i,
  output rem_t             rem_o,
  output logic             done_o
);

  localparam logic [14:0] RECIP_62 = 15'd16913;
  localparam logic [13:0] BASE_62  = 14'd62;

  logic [VALUE_W-1:0] mem_q [MAX_DIGITS];
  logic [VALUE_W-1:0] rdata_q;

  logic               busy_q, busy_d;
  logic               dir_q, dir_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [LEN_W-1:0]   pass_q, pass_d;
  logic [CNT_W-1:0]   rd_idx_q, rd_idx_d;
  logic               pv_q, pv_d;
  logic [IDX_W-1:0]   wr_idx_q, wr_idx_d;
  logic [VALUE_W-1:0] rem_q, rem_d;

  logic               rd_more, rd_en, pass_end;
  logic [13:0]        acc_enc, acc_dec, r_enc;
  logic [28:0]        prod;
  logic [VALUE_W-1:0] q_enc, q_dec, step_quot, step_rem;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;

  // one division step: quotient digit and running remainder
  assign acc_enc = {rem_q[5:0], rdata_q};
  assign prod    = 29'(acc_enc) * 29'(RECIP_62);
  assign q_enc   = prod[27:20];
  assign r_enc   = acc_enc - ({6'b0, q_enc} * BASE_62);
  assign acc_dec = ({6'b0, rem_q} * BASE_62) + {6'b0, rdata_q};
  assign q_dec   = {2'b00, acc_dec[13:8]};

  assign step_quot = (dir_q == DIR_DECODE) ? q_dec : q_enc;
  assign step_rem  = (dir_q == DIR_DECODE) ? acc_dec[7:0] : {2'b00, r_enc[5:0]};

  assign rd_more  = (rd_idx_q != cnt_q);
  assign rd_en    = busy_q && rd_more;
  assign pass_end = busy_q && !rd_more && !pv_q;

  assign rem_o.valid = pass_end;
  assign rem_o.value = rem_q;
  assign done_o      = pass_end && (pass_q == LEN_W'(1));

  always_comb begin
    busy_d   = busy_q;
    dir_d    = dir_q;
    cnt_d    = cnt_q;
    pass_d   = pass_q;
    rd_idx_d = rd_idx_q;
    pv_d     = pv_q;
    wr_idx_d = wr_idx_q;
    rem_d    = rem_q;
    if (start_i) begin
      busy_d   = 1'b1;
      dir_d    = dir_i;
      cnt_d    = count_i;
      pass_d   = passes_i;
      rd_idx_d = '0;
      pv_d     = 1'b0;
      rem_d    = '0;
    end else if (busy_q) begin
      pv_d     = rd_en;
      wr_idx_d = rd_idx_q[IDX_W-1:0];
      if (rd_en) begin
        rd_idx_d = rd_idx_q + 1'b1;
      end
      if (pv_q) begin
        rem_d = step_rem;
      end
      if (pass_end) begin
        rem_d    = '0;
        rd_idx_d = '0;
        pass_d   = pass_q - 1'b1;
        if (pass_q == LEN_W'(1)) begin
          busy_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      dir_q    <= DIR_ENCODE;
      cnt_q    <= '0;
      pass_q   <= '0;
      rd_idx_q <= '0;
      pv_q     <= 1'b0;
      wr_idx_q <= '0;
      rem_q    <= '0;
    end else begin
      busy_q   <= busy_d;
      dir_q    <= dir_d;
      cnt_q    <= cnt_d;
      pass_q   <= pass_d;
      rd_idx_q <= rd_idx_d;
      pv_q     <= pv_d;
      wr_idx_q <= wr_idx_d;
      rem_q    <= rem_d;
    end
  end

  // write-back trails the read by one entry, so no same-entry overlap
  assign mem_we    = busy_q ? pv_q : ld_i.en;
  assign mem_waddr = busy_q ? wr_idx_q : ld_addr_i;
  assign mem_wdata = busy_q ? step_quot : ld_i.data;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_idx_q[IDX_W-1:0]];
    end
  end

  `B62C_IMPLY(a_rd_idx_bound, busy_q, rd_idx_q <= cnt_q, "read index beyond digit count")
  `B62C_IMPLY(a_rem_range, rem_o.valid, (dir_q == DIR_DECODE) || (rem_q < 8'd62), "remainder out of range")

endmodule

// ===== hw/rtl/b62c_out.sv =====
`timescale 1ns / 1ps
`include "base62_codec_macros.svh"
// ----------------------------------------------------------------------------
// b62c_out
// result store and output beat sequencer with output register
// ----------------------------------------------------------------------------
module b62c_out
  import b62c_pkg::*;
#(
  parameter int unsigned  MAX_DIGITS = 48,
  localparam int unsigned IDX_W      = $clog2(MAX_DIGITS)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rem_t               rem_i,
  input  emit_cmd_t          cmd_i,
  output logic               done_o,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [VALUE_W-1:0] m_axis_tdata_o,   // value_res[7:0]
  output logic               m_axis_tlast_o,
  output logic [ERR_W-1:0]   m_axis_tuser_o    // error[1:0]
);

  localparam logic [1:0] OS_IDLE = 2'd0;
  localparam logic [1:0] OS_RD   = 2'd1;
  localparam logic [1:0] OS_PUSH = 2'd2;
  localparam logic [1:0] OS_ERR  = 2'd3;

  logic [VALUE_W-1:0] mem_q [MAX_DIGITS];
  logic [VALUE_W-1:0] rdata_q;

  logic [1:0]         state_q, state_d;
  logic               dir_q, dir_d;
  logic [ERR_W-1:0]   code_q, code_d;
  logic [IDX_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [IDX_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic               outv_q, outv_d;
  logic [VALUE_W-1:0] data_q, data_d;
  logic               last_q, last_d;
  logic [ERR_W-1:0]   user_q, user_d;

  logic               slot_free, rd_en;

  assign slot_free = !outv_q || m_axis_tready_i;

  always_comb begin
    state_d  = state_q;
    dir_d    = dir_q;
    code_d   = code_q;
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    outv_d   = outv_q;
    data_d   = data_q;
    last_d   = last_q;
    user_d   = user_q;
    rd_en    = 1'b0;
    done_o   = 1'b0;
    if (m_axis_tready_i) begin
      outv_d = 1'b0;
    end
    if (rem_i.valid) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    case (state_q)
      OS_IDLE: begin
        if (cmd_i.start) begin
          wr_ptr_d = '0;
          dir_d    = cmd_i.dir;
          code_d   = cmd_i.code;
          rd_ptr_d = IDX_W'(cmd_i.len - LEN_W'(1));
          state_d  = cmd_i.err ? OS_ERR : OS_RD;
        end
      end
      OS_RD: begin
        rd_en   = 1'b1;
        state_d = OS_PUSH;
      end
      OS_PUSH: begin
        if (slot_free) begin
          outv_d = 1'b1;
          data_d = (dir_q == DIR_DECODE) ? rdata_q : digit_to_char(rdata_q[5:0]);
          last_d = (rd_ptr_q == '0);
          user_d = ERR_NONE;
          if (rd_ptr_q == '0) begin
            done_o  = 1'b1;
            state_d = OS_IDLE;
          end else begin
            rd_ptr_d = rd_ptr_q - 1'b1;
            state_d  = OS_RD;
          end
        end
      end
      OS_ERR: begin
        if (slot_free) begin
          outv_d  = 1'b1;
          data_d  = '0;
          last_d  = 1'b1;
          user_d  = code_q;
          done_o  = 1'b1;
          state_d = OS_IDLE;
        end
      end
      default: begin
        state_d = OS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= OS_IDLE;
      dir_q    <= DIR_ENCODE;
      code_q   <= ERR_NONE;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      outv_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      dir_q    <= dir_d;
      code_q   <= code_d;
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      outv_q   <= outv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    last_q <= last_d;
    user_q <= user_d;
  end

  // remainders land low digit first, read back from the top
  always_ff @(posedge clk_i) begin
    if (rem_i.valid) begin
      mem_q[wr_ptr_q] <= rem_i.value;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_ptr_q];
    end
  end

  assign m_axis_tvalid_o = outv_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tlast_o  = last_q;
  assign m_axis_tuser_o  = user_q;

  `B62C_IMPLY(a_rem_when_idle, rem_i.valid, state_q == OS_IDLE, "remainder while emitting")
  `B62C_IMPLY(a_err_is_last, outv_q && (user_q != ERR_NONE), last_q, "error beat not last")

endmodule

// ===== hw/rtl/base62_codec.sv =====
`timescale 1ns / 1ps
`include "base62_codec_macros.svh"
// ----------------------------------------------------------------------------
// base62_codec
// base62 encoder and decoder for big-endian numbers of up to MAX_DIGITS digits
// loading: one input beat per cycle, only while in the load state; valid digits go into the digit store
// conversion: n passes of long division over the stored digits, n = clamped out_length
// output: result beats from the result store, each read and then pushed into the output register
// error run: one error beat after the last input beat, through the error state and output register
// reset: asynchronous, clears control and config; stores are not cleared
// ----------------------------------------------------------------------------
module base62_codec
  import b62c_pkg::*;
#(
  parameter int unsigned  MAX_DIGITS = 48,
  localparam int unsigned IDX_W      = $clog2(MAX_DIGITS),
  localparam int unsigned CNT_W      = $clog2(MAX_DIGITS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [VALUE_W-1:0]    s_axis_tdata_i,   // value[7:0]
  input  logic                  s_axis_tlast_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [VALUE_W-1:0]    m_axis_tdata_o,   // value_res[7:0]
  output logic                  m_axis_tlast_o,
  output logic [ERR_W-1:0]      m_axis_tuser_o    // error[1:0]
);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state_q, state_d;
  logic             dir_q;
  logic [LEN_W-1:0] out_len_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [ERR_W-1:0] err_q, err_d;
  logic             conv_dir_q;
  logic [LEN_W-1:0] conv_len_q;

  logic             in_fire, store_full, div_start, div_done, emit_done;
  logic [LEN_W-1:0] len_clamp;
  digit_t           dig;
  ld_wr_t           ld;
  rem_t             rem;
  emit_cmd_t        emit_cmd;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_LOAD);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign store_full      = (count_q == CNT_W'(MAX_DIGITS));

  always_comb begin
    if (dir_q == DIR_DECODE) begin
      dig = char_to_digit(s_axis_tdata_i);
    end else begin
      dig.ok    = 1'b1;
      dig.digit = s_axis_tdata_i;
    end
  end

  always_comb begin
    if (out_len_q == '0) begin
      len_clamp = LEN_W'(1);
    end else if ({1'b0, out_len_q} > (LEN_W + 1)'(MAX_DIGITS)) begin
      len_clamp = LEN_W'(MAX_DIGITS);
    end else begin
      len_clamp = out_len_q;
    end
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    err_d     = err_q;
    ld.en     = 1'b0;
    ld.data   = dig.digit;
    div_start = 1'b0;
    emit_cmd  = '0;
    case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          if (!dig.ok) begin
            if (err_q == ERR_NONE) begin
              err_d = ERR_CHAR;
            end
          end else if (store_full) begin
            if (err_q == ERR_NONE) begin
              err_d = ERR_OVERFLOW;
            end
          end else begin
            ld.en   = 1'b1;
            count_d = count_q + 1'b1;
          end
          if (s_axis_tlast_i) begin
            if (err_d != ERR_NONE) begin
              emit_cmd.start = 1'b1;
              emit_cmd.err   = 1'b1;
              emit_cmd.code  = err_d;
              err_d          = ERR_NONE;
              count_d        = '0;
              state_d        = ST_EMIT;
            end else begin
              div_start = 1'b1;
              state_d   = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          emit_cmd.start = 1'b1;
          emit_cmd.dir   = conv_dir_q;
          emit_cmd.len   = conv_len_q;
          count_d        = '0;
          state_d        = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_done) begin
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      count_q    <= '0;
      err_q      <= ERR_NONE;
      conv_dir_q <= DIR_ENCODE;
      conv_len_q <= OUT_LEN_RESET;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      err_q   <= err_d;
      if (div_start) begin
        conv_dir_q <= dir_q;
        conv_len_q <= len_clamp;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q     <= DIR_ENCODE;
      out_len_q <= OUT_LEN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_DIRECTION:  dir_q     <= cfg_data_i[0];
        REG_OUT_LENGTH: out_len_q <= cfg_data_i[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  b62c_div #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ld_i     (ld),
    .ld_addr_i(count_q[IDX_W-1:0]),
    .start_i  (div_start),
    .dir_i    (dir_q),
    .count_i  (count_d),
    .passes_i (len_clamp),
    .rem_o    (rem),
    .done_o   (div_done)
  );

  b62c_out #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rem_i          (rem),
    .cmd_i          (emit_cmd),
    .done_o         (emit_done),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  `B62C_ASSERT(a_count_range, count_q <= CNT_W'(MAX_DIGITS), "digit count beyond store")
  `B62C_IMPLY(a_err_clear_busy, state_q != ST_LOAD, err_q == ERR_NONE, "error kept past run end")

endmodule

// ===== test/base62_codec_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base62_codec_tb
// self-checking bench: runs of bytes or base62 characters go in as beats, a
// behavioural model in the bench predicts every result beat from the accepted
// input and the live register values; random gaps on the input and random
// back-pressure on the output are applied to the two streams
// ----------------------------------------------------------------------------
module base62_codec_tb;
  import b62c_pkg::*;

  localparam int unsigned STORE_DEPTH   = 48;
  localparam int unsigned BASE_CHARS    = 62;
  localparam int unsigned BASE_BYTES    = 256;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES  = 200;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd5;
  localparam string ALPHABET =
    "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";

  typedef enum logic [1:0] {
    PACE_SLOW_RX,
    PACE_SLOW_TX,
    PACE_FREE
  } pace_e;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               last;
  } char_beat_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               last;
    logic [ERR_W-1:0]   err;
  } digit_beat_t;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [VALUE_W-1:0]    s_tdata   = '0;
  logic                  s_tlast   = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [VALUE_W-1:0]    m_tdata;
  logic                  m_tlast;
  logic [ERR_W-1:0]      m_tuser;

  // bench copy of the codec state
  logic [VALUE_W-1:0] num_digits [STORE_DEPTH];
  int unsigned        num_len  = 0;
  logic [ERR_W-1:0]   run_err  = ERR_NONE;
  logic               mode_dir = DIR_ENCODE;
  logic [LEN_W-1:0]   mode_len = OUT_LEN_RESET;

  char_beat_t  char_q [$];
  digit_beat_t expected_q [$];

  logic        in_taken = 1'b0;
  logic        rx_hold  = 1'b0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int          fail_cnt = 0;
  int          runs_done = 0;
  int          error_runs = 0;
  int          beats_checked = 0;
  event        hold_ev;

  base62_codec u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report(input string msg);
    fail_cnt++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic bit char_digit(input logic [VALUE_W-1:0] c,
                                    output logic [VALUE_W-1:0] d);
    d = '0;
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = c - CH_LA + 8'd10;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = c - CH_UA + 8'd36;
    end else begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // load one beat; on the closing beat convert and queue the result beats, or one error beat
  task automatic absorb_beat(input logic [VALUE_W-1:0] v, input logic last);
    logic [VALUE_W-1:0] d;
    logic [VALUE_W-1:0] res [STORE_DEPTH];
    bit                 ok;
    int unsigned        n, radix, target, acc, rem, k, i;
    digit_beat_t        b;
    d  = v;
    ok = 1'b1;
    if (mode_dir == DIR_DECODE) begin
      ok = char_digit(v, d);
    end
    if (!ok) begin
      if (run_err == ERR_NONE) run_err = ERR_CHAR;
    end else if (num_len >= STORE_DEPTH) begin
      if (run_err == ERR_NONE) run_err = ERR_OVERFLOW;
    end else begin
      num_digits[num_len] = d;
      num_len++;
    end
    if (!last) return;
    runs_done++;
    if (run_err != ERR_NONE) begin
      error_runs++;
      b.value = '0;
      b.last  = 1'b1;
      b.err   = run_err;
      expected_q = {expected_q, b};
    end else begin
      n = mode_len;
      if (n == 0) n = 1;
      if (n > STORE_DEPTH) n = STORE_DEPTH;
      radix  = (mode_dir == DIR_DECODE) ? BASE_CHARS : BASE_BYTES;
      target = (mode_dir == DIR_DECODE) ? BASE_BYTES : BASE_CHARS;
      for (k = 0; k < n; k++) begin
        rem = 0;
        for (i = 0; i < num_len; i++) begin
          acc = num_digits[i] + rem * radix;
          rem = acc % target;
          num_digits[i] = VALUE_W'(acc / target);
        end
        res[n-1-k] = rem[VALUE_W-1:0];
      end
      for (k = 0; k < n; k++) begin
        b.value = (mode_dir == DIR_ENCODE) ? ALPHABET[res[k] % BASE_CHARS] : res[k];
        b.last  = (k == n - 1);
        b.err   = ERR_NONE;
        expected_q = {expected_q, b};
      end
    end
    num_len = 0;
    run_err = ERR_NONE;
  endtask

  task automatic check_beat();
    digit_beat_t want;
    beats_checked++;
    if (expected_q.size() == 0) begin
      report($sformatf("beat with nothing expected: data=%h last=%b err=%0d",
                       m_tdata, m_tlast, m_tuser));
      return;
    end
    want = expected_q.pop_front();
    if (m_tdata !== want.value) begin
      report($sformatf("value_res got %h want %h", m_tdata, want.value));
    end
    if (m_tlast !== want.last) begin
      report($sformatf("last_res got %b want %b", m_tlast, want.last));
    end
    if (m_tuser !== want.err) begin
      report($sformatf("error got %0d want %0d", m_tuser, want.err));
    end
  endtask

  // monitor: register writes, input beats into the model, output beats checked
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_DIRECTION) begin
          mode_dir = cfg_data[0];
        end else if (cfg_index == REG_OUT_LENGTH) begin
          mode_len = cfg_data[LEN_W-1:0];
        end
      end
      in_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) absorb_beat(s_tdata, s_tlast);
      if (m_tvalid && m_tready) check_beat();
    end
  end

  // driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (char_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= char_q[0].value;
        s_tlast  <= char_q[0].last;
        void'(char_q.pop_front());
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // long receiver hold-off
  always begin
    @(hold_ev);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  task automatic set_pace(input pace_e p);
    case (p)
      PACE_SLOW_RX: begin
        tx_idle_pct = 32;
        rx_idle_pct = 59;
      end
      PACE_SLOW_TX: begin
        tx_idle_pct = 59;
        rx_idle_pct = 32;
      end
      default: begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
    endcase
  endtask

  task automatic push_char(input logic [VALUE_W-1:0] v, input logic last);
    char_beat_t c;
    c.value = v;
    c.last  = last;
    char_q = {char_q, c};
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (char_q.size() != 0 || s_tvalid || expected_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // clean runs carry only alphabet characters when decoding
  task automatic random_run(input int unsigned len, input bit clean);
    int unsigned        j;
    logic [VALUE_W-1:0] v;
    for (j = 0; j < len; j++) begin
      if (mode_dir == DIR_DECODE && (clean || $urandom_range(24) != 0)) begin
        v = ALPHABET[$urandom_range(BASE_CHARS - 1)];
      end else begin
        v = VALUE_W'($urandom_range(255));
      end
      push_char(v, j == len - 1);
    end
  endtask

  task automatic random_config();
    logic [CFG_DATA_W-1:0] len;
    case ($urandom_range(4))
      0: len = 8'd1;
      1: len = CFG_DATA_W'(STORE_DEPTH);
      2: len = CFG_DATA_W'($urandom_range(63, STORE_DEPTH + 1));
      default: len = CFG_DATA_W'($urandom_range(STORE_DEPTH - 1, 2));
    endcase
    cfg_write(REG_DIRECTION, CFG_DATA_W'($urandom_range(1)));
    cfg_write(REG_OUT_LENGTH, len);
  endtask

  initial begin
    int unsigned ph, fill, len, i;
    set_pace(PACE_SLOW_RX);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // encode with reset settings: zero, all ones, leading zeros
    push_char(8'h00, 1'b1);
    for (i = 0; i < 4; i++) push_char(8'hFF, i == 3);
    push_char(8'h00, 1'b0);
    push_char(8'h00, 1'b0);
    push_char(8'h01, 1'b1);
    wait_idle();
    // length 0 acts as 1, high digits dropped
    cfg_write(REG_OUT_LENGTH, 8'd0);
    push_char(8'hFF, 1'b0);
    push_char(8'hFF, 1'b1);
    wait_idle();
    // length above the store clamps
    cfg_write(REG_OUT_LENGTH, 8'd63);
    push_char(8'h7F, 1'b1);
    wait_idle();
    // decode, with the length register masked to 6 bits
    cfg_write(REG_DIRECTION, 8'h03);
    cfg_write(REG_OUT_LENGTH, 8'd70);
    push_char(CH_0, 1'b1);
    push_char(CH_UZ, 1'b0);
    push_char(CH_LZ, 1'b0);
    push_char(CH_9, 1'b0);
    push_char(CH_UA, 1'b1);
    push_char(CH_LA, 1'b0);
    push_char(8'h21, 1'b0);
    push_char(8'h62, 1'b1);
    wait_idle();
    // direction flips partway through a run
    cfg_write(REG_OUT_LENGTH, 8'd4);
    push_char(CH_UZ, 1'b0);
    push_char(CH_UZ, 1'b0);
    wait_idle();
    cfg_write(REG_DIRECTION, 8'h00);
    cfg_write(REG_SPARE, 8'hA5);
    push_char(8'hFF, 1'b1);
    wait_idle();

    for (ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        set_pace(PACE_SLOW_RX);
      end else if (ph < 4) begin
        set_pace(PACE_SLOW_TX);
      end else begin
        set_pace(PACE_FREE);
      end
      random_config();
      if (ph == 2) -> hold_ev;
      // one run past the end of the store
      if (ph == 3) random_run(STORE_DEPTH + 1, 1'b1);
      fill = 0;
      while (fill < 5) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 1);
        random_run(len, 1'b0);
        fill += len;
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d runs in both directions, %0d of them closed by an error beat",
             runs_done, error_runs);
    $display("%0d result beats checked under mixed stalls and a long output hold-off",
             beats_checked);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("timeout with %0d beats still expected", expected_q.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/b62c_pkg.sv
hw/rtl/b62c_div.sv
hw/rtl/b62c_out.sv
hw/rtl/base62_codec.sv
test/base62_codec_tb.sv
